// File: design/cdq_pkg.sv
// Shared types, widths and codes of the circular deque.
package cdq_pkg;

	// Depth of the ring and fixed field widths
	localparam int CDQ_DEPTH    = 16;
	localparam int CDQ_DATA_W   = 32;
	localparam int CDQ_MODE_W   = 3;
	localparam int CDQ_STATUS_W = 2;
	localparam int CDQ_COUNT_W  = 5;
	localparam int CDQ_CAP_W    = 5;

	// Capacity register after reset
	localparam logic [CDQ_CAP_W-1:0] CDQ_CAP_RESET = 5'd16;

	// Operation codes
	localparam logic [CDQ_MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [CDQ_MODE_W-1:0] MODE_POP_FRONT  = 3'd1;
	localparam logic [CDQ_MODE_W-1:0] MODE_PUSH_REAR  = 3'd2;
	localparam logic [CDQ_MODE_W-1:0] MODE_POP_REAR   = 3'd3;
	localparam logic [CDQ_MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
	localparam logic [CDQ_MODE_W-1:0] MODE_CLEAR      = 3'd5;

	// Status codes
	localparam logic [CDQ_STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [CDQ_STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [CDQ_STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	// One request
	typedef struct packed {
		logic [CDQ_MODE_W-1:0] mode;
		logic [CDQ_DATA_W-1:0] value;
	} req_t;

	// One result
	typedef struct packed {
		logic [CDQ_DATA_W-1:0]   data;
		logic [CDQ_STATUS_W-1:0] status;
		logic [CDQ_COUNT_W-1:0]  count;
		logic                    is_empty;
		logic                    is_full;
	} rsp_t;

	// Write into the ring, applied at the tail cell
	typedef struct packed {
		logic                  wr;
		logic [CDQ_DATA_W-1:0] wr_data;
	} ring_ctl_t;

endpackage

// File: design/cdq_cell.sv
// One storage cell of the rotating slot ring.
module cdq_cell
	import cdq_pkg::*;
(
	input  logic                  clk,
	input  logic [CDQ_DATA_W-1:0] shift_in,
	input  logic                  load,
	input  logic [CDQ_DATA_W-1:0] load_data,
	output logic [CDQ_DATA_W-1:0] q
);

	logic [CDQ_DATA_W-1:0] data_q;

	// Take the neighbour's slot, or new data when loading
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else begin
			data_q <= shift_in;
		end
	end

	assign q = data_q;

endmodule

// File: design/cdq_ctrl.sv
// Sequencer of the circular deque: indices, count, ring head tracking, results.
module cdq_ctrl
	import cdq_pkg::*;
#(
	parameter int DEPTH = CDQ_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_we,
	input  logic [CDQ_CAP_W-1:0]  cfg_wdata,
	input  logic [CDQ_DATA_W-1:0] head,
	output ring_ctl_t             ring
);

	localparam int IW = $clog2(DEPTH);
	localparam int WW = CDQ_CAP_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEEK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]              state_q;
	logic [1:0]              state_d;
	logic [CDQ_CAP_W-1:0]    cap_q;
	logic [IW-1:0]           pos_q;
	logic [IW-1:0]           front_q;
	logic [IW-1:0]           rear_q;
	logic [CDQ_COUNT_W-1:0]  count_q;
	logic [CDQ_MODE_W-1:0]   mode_q;
	logic [CDQ_DATA_W-1:0]   value_q;
	rsp_t                    res_q;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;

	logic [WW-1:0]           cap;
	logic                    full;
	logic                    empty;
	logic                    need_slot;
	logic                    wr_op;
	logic                    hit;
	logic [IW-1:0]           target;
	logic [IW-1:0]           nxt_front;
	logic [IW-1:0]           nxt_rear;
	logic [CDQ_COUNT_W-1:0]  nxt_count;
	logic [CDQ_DATA_W-1:0]   res_data;
	logic [CDQ_STATUS_W-1:0] res_status;
	logic                    accept;
	logic                    out_free;

	// Forward step with wrap at the capacity
	function automatic logic [IW-1:0] step_up(input logic [IW-1:0] idx,
		input logic [WW-1:0] c);
		logic [WW-1:0] n;
		n = WW'(idx) + WW'(1);
		return (n >= c) ? '0 : IW'(n);
	endfunction

	// Backward step with wrap at the capacity
	function automatic logic [IW-1:0] step_down(input logic [IW-1:0] idx,
		input logic [WW-1:0] c);
		logic [WW-1:0] m;
		m = c - WW'(1);
		return (idx == '0 || WW'(idx) > c) ? IW'(m) : idx - IW'(1);
	endfunction

	// Clamp the capacity register into one to DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap = WW'(1);
		end else if (WW'(cap_q) > WW'(DEPTH)) begin
			cap = WW'(DEPTH);
		end else begin
			cap = WW'(cap_q);
		end
	end

	assign full  = WW'(count_q) >= cap;
	assign empty = count_q == '0;

	// Decode the held request against the current indices
	always_comb begin
		need_slot  = 1'b0;
		wr_op      = 1'b0;
		target     = front_q;
		nxt_front  = front_q;
		nxt_rear   = rear_q;
		nxt_count  = count_q;
		res_data   = '0;
		res_status = STATUS_OK;
		unique case (mode_q)
			MODE_PUSH_FRONT: begin
				if (full) begin
					res_status = STATUS_FULL;
				end else begin
					need_slot = 1'b1;
					wr_op     = 1'b1;
					target    = step_down(front_q, cap);
					nxt_front = target;
					nxt_count = count_q + CDQ_COUNT_W'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					res_status = STATUS_EMPTY;
				end else begin
					need_slot = 1'b1;
					target    = front_q;
					res_data  = head;
					nxt_front = step_up(front_q, cap);
					nxt_count = count_q - CDQ_COUNT_W'(1);
				end
			end
			MODE_PUSH_REAR: begin
				if (full) begin
					res_status = STATUS_FULL;
				end else begin
					need_slot = 1'b1;
					wr_op     = 1'b1;
					target    = step_up(rear_q, cap);
					nxt_rear  = target;
					nxt_count = count_q + CDQ_COUNT_W'(1);
				end
			end
			MODE_POP_REAR: begin
				if (empty) begin
					res_status = STATUS_EMPTY;
				end else begin
					need_slot = 1'b1;
					target    = rear_q;
					res_data  = head;
					nxt_rear  = step_down(rear_q, cap);
					nxt_count = count_q - CDQ_COUNT_W'(1);
				end
			end
			MODE_PEEK_FRONT: begin
				if (empty) begin
					res_status = STATUS_EMPTY;
				end else begin
					need_slot = 1'b1;
					target    = front_q;
					res_data  = head;
				end
			end
			MODE_CLEAR: begin
				nxt_front = IW'(1);
				nxt_rear  = '0;
				nxt_count = '0;
			end
			default: begin
			end
		endcase
	end

	// Slot lined up at the ring head, or none needed
	assign hit      = !need_slot || (pos_q == target);
	assign accept   = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SEEK;
				end
			end
			ST_SEEK: begin
				if (hit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state, indices, count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CDQ_CAP_RESET;
			pos_q       <= '0;
			front_q     <= IW'(1);
			rear_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// advance the head pointer with the ring
			pos_q <= (pos_q == IW'(DEPTH - 1)) ? '0 : pos_q + IW'(1);
			if (state_q == ST_SEEK && hit) begin
				front_q <= nxt_front;
				rear_q  <= nxt_rear;
				count_q <= nxt_count;
			end
			if (state_q == ST_EMIT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the request and build the result
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= req.mode;
			value_q <= req.value;
		end
		if (state_q == ST_SEEK && hit) begin
			res_q.data     <= res_data;
			res_q.status   <= res_status;
			res_q.count    <= nxt_count;
			res_q.is_empty <= nxt_count == '0;
			res_q.is_full  <= WW'(nxt_count) >= cap;
		end
		if (state_q == ST_EMIT && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign req_stall    = state_q != ST_IDLE;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;
	assign ring.wr      = (state_q == ST_SEEK) && hit && wr_op;
	assign ring.wr_data = value_q;

`ifndef SYNTHESIS
	a_write_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		ring.wr |-> (state_q == ST_SEEK && pos_q == target))
		else $error("ring write away from the addressed slot");

	a_accept_seek: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SEEK))
		else $error("accepted request did not start a seek");

	a_count_on_seek: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == ST_SEEK))
		else $error("count changed outside a completed operation");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(front_q) < WW'(DEPTH)) && (WW'(rear_q) < WW'(DEPTH))
		&& (WW'(count_q) <= WW'(DEPTH)))
		else $error("index or count beyond the ring depth");
`endif

endmodule

// File: design/circular_deque.sv
// Top level of the circular deque: rotating ring of slot cells and its sequencer.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_t  {mode, value}
//   rsp      out        rsp_valid/rsp_stall   rsp_t  {data, status, count, is_empty, is_full}
//   cfg      in         cfg_we                cfg_wdata (capacity in use)
//
// A taken request passes the seek and emit steps; in seek the sequencer waits for the addressed
// slot to rotate round the ring to the head cell, a wait that clear, refused and unused
// operations skip. The next request is taken only once the result has been issued.
// A stalled result holds the sequencer in its emit step; one more request is still taken
// while that result waits. Reset sets indices, count and capacity; slots stay undefined.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int DEPTH = CDQ_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CDQ_CAP_W-1:0] cfg_wdata
);

	logic [CDQ_DATA_W-1:0] cell_data [DEPTH];
	ring_ctl_t             ring;

	// Rotate slots one cell towards the head each cycle; load at the tail
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_tail
			cdq_cell u_cell (
				.clk       (clk),
				.shift_in  (cell_data[0]),
				.load      (ring.wr),
				.load_data (ring.wr_data),
				.q         (cell_data[i])
			);
		end else begin : g_body
			cdq_cell u_cell (
				.clk       (clk),
				.shift_in  (cell_data[i+1]),
				.load      (1'b0),
				.load_data ('0),
				.q         (cell_data[i])
			);
		end
	end

	// Sequence requests against the ring head
	cdq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (cell_data[0]),
		.ring      (ring)
	);

endmodule

// File: test/deque_checker.sv
// Result checker for the circular deque: predicts each result and compares it on arrival.
module deque_checker
	import cdq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  req_t                 req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CDQ_CAP_W-1:0] cfg_wdata,
	output int                   open_count,
	output int                   mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W       = $clog2(CDQ_DEPTH);
	localparam int PRINT_LIMIT = 100;

	// Predicted deque state and capacity register
	logic [CDQ_DATA_W-1:0]  ring [CDQ_DEPTH];
	logic [IDX_W-1:0]       head_idx;
	logic [IDX_W-1:0]       tail_idx;
	logic [CDQ_COUNT_W-1:0] held;
	logic [CDQ_CAP_W-1:0]   cap_reg;
	rsp_t                   awaited_q [$];
	int                     fail_total = 0;

	assign mismatches = fail_total;

	// Print one line per mismatch and count it; keep the log bounded
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fail_total < PRINT_LIMIT) begin
			$display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		end
		fail_total++;
	endtask

	// Clamp the register to the range the ring supports
	function automatic int slots_in_use();
		if (cap_reg == 0) begin
			return 1;
		end
		if (cap_reg > CDQ_DEPTH) begin
			return CDQ_DEPTH;
		end
		return int'(cap_reg);
	endfunction

	// Advance an index, wrapping once it reaches or passes the capacity
	function automatic logic [IDX_W-1:0] index_up(input logic [IDX_W-1:0] idx);
		int nxt;
		nxt = int'(idx) + 1;
		return (nxt >= slots_in_use()) ? '0 : IDX_W'(nxt);
	endfunction

	// Step an index back, wrapping to the last slot in use
	function automatic logic [IDX_W-1:0] index_down(input logic [IDX_W-1:0] idx);
		int lim;
		lim = slots_in_use();
		if (idx == 0 || int'(idx) > lim) begin
			return IDX_W'(lim - 1);
		end
		return idx - 1'b1;
	endfunction

	function automatic void reset_pointers();
		head_idx = IDX_W'(1);
		tail_idx = '0;
		held     = '0;
	endfunction

	// Apply one request to the predicted state and build its result
	task automatic apply_request(input req_t r, output rsp_t res);
		logic was_full;
		logic was_empty;
		was_full  = int'(held) >= slots_in_use();
		was_empty = held == 0;
		res = '0;
		res.status = STATUS_OK;
		case (r.mode)
			MODE_PUSH_FRONT: begin
				if (was_full) begin
					res.status = STATUS_FULL;
				end else begin
					head_idx = index_down(head_idx);
					ring[head_idx] = r.value;
					held = held + 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (was_empty) begin
					res.status = STATUS_EMPTY;
				end else begin
					res.data = ring[head_idx];
					head_idx = index_up(head_idx);
					held = held - 1'b1;
				end
			end
			MODE_PUSH_REAR: begin
				if (was_full) begin
					res.status = STATUS_FULL;
				end else begin
					tail_idx = index_up(tail_idx);
					ring[tail_idx] = r.value;
					held = held + 1'b1;
				end
			end
			MODE_POP_REAR: begin
				if (was_empty) begin
					res.status = STATUS_EMPTY;
				end else begin
					res.data = ring[tail_idx];
					tail_idx = index_down(tail_idx);
					held = held - 1'b1;
				end
			end
			MODE_PEEK_FRONT: begin
				if (was_empty) begin
					res.status = STATUS_EMPTY;
				end else begin
					res.data = ring[head_idx];
				end
			end
			MODE_CLEAR: begin
				reset_pointers();
			end
			default: begin
			end
		endcase
		res.count    = held;
		res.is_empty = held == 0;
		res.is_full  = int'(held) >= slots_in_use();
	endtask

	// Watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		rsp_t pred;
		if (!arst_n) begin
			cap_reg = CDQ_CAP_RESET;
			reset_pointers();
			foreach (ring[i]) begin
				ring[i] = '0;
			end
			awaited_q.delete();
			open_count <= 0;
		end else begin
			// compare a delivered result with the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (awaited_q.size() == 0) begin
					report_mismatch("result with no request waiting", 64'(rsp.data), '0);
				end else begin
					want = awaited_q.pop_front();
					if (rsp.data !== want.data) begin
						report_mismatch("data", 64'(rsp.data), 64'(want.data));
					end
					if (rsp.status !== want.status) begin
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
					end
					if (rsp.count !== want.count) begin
						report_mismatch("count", 64'(rsp.count), 64'(want.count));
					end
					if (rsp.is_empty !== want.is_empty) begin
						report_mismatch("is_empty", 64'(rsp.is_empty), 64'(want.is_empty));
					end
					if (rsp.is_full !== want.is_full) begin
						report_mismatch("is_full", 64'(rsp.is_full), 64'(want.is_full));
					end
				end
			end
			// predict the result of an accepted request
			if (req_valid && !req_stall) begin
				apply_request(req, pred);
				awaited_q.push_back(pred);
			end
			// track the capacity register
			if (cfg_we) begin
				cap_reg = cfg_wdata;
			end
			open_count <= awaited_q.size();
		end
	end

endmodule

// File: test/testbench.sv
// Testbench top for the circular deque: clock, reset, request and result drivers, verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cdq_pkg::*;

	// Modes the block treats as no operation
	localparam logic [CDQ_MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
	localparam logic [CDQ_MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SEGMENTS      = 9;
	localparam int SEGMENT_ITEMS = 72;
	localparam int CHUNK_ITEMS   = 24;
	localparam int HOLD_SEGMENT  = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we    = 1'b0;
	logic [CDQ_CAP_W-1:0] cfg_wdata = CDQ_CAP_RESET;

	int open_count;
	int mismatches;
	int cycle_count = 0;
	int idle_pct    = 0;
	int stall_pct   = 0;
	int segment     = -1;
	int hold_left   = 0;
	bit hold_done   = 1'b0;

	circular_deque dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	deque_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.open_count (open_count),
		.mismatches (mismatches)
	);

	always #4 clk = ~clk;

	// Abandon a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stall results at random; hold off once for a long stretch so the deque backs up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (segment == HOLD_SEGMENT && !hold_done) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic req_t make_req(input logic [CDQ_MODE_W-1:0] mode,
			input logic [CDQ_DATA_W-1:0] value);
		req_t r;
		r.mode  = mode;
		r.value = value;
		return r;
	endfunction

	// Draw a request, leaning towards pushes or pops
	function automatic req_t random_request(input bit fill_lean);
		int                    roll;
		int                    push_pct;
		logic [CDQ_MODE_W-1:0] mode;
		logic [CDQ_DATA_W-1:0] value;
		roll     = $urandom_range(99);
		push_pct = fill_lean ? 65 : 30;
		if (roll < push_pct) begin
			mode = $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
		end else if (roll < 88) begin
			mode = $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR;
		end else if (roll < 97) begin
			mode = MODE_PEEK_FRONT;
		end else if (roll < 98) begin
			mode = MODE_CLEAR;
		end else begin
			mode = $urandom_range(1) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
		end
		case ($urandom_range(7))
			0: value = 32'h0000_0000;
			1: value = 32'hFFFF_FFFF;
			default: value = $urandom;
		endcase
		return make_req(mode, value);
	endfunction

	// Capacity for each random segment, extremes and out-of-range values among them
	function automatic logic [CDQ_CAP_W-1:0] capacity_for(input int seg);
		case (seg)
			0: return 5'd16;
			1: return 5'd3;
			2: return 5'd1;
			3: return 5'd0;
			4: return 5'd31;
			5: return 5'd7;
			6: return 5'd2;
			7: return 5'd12;
			default: return 5'd16;
		endcase
	endfunction

	task automatic set_idling(input int phase);
		case (phase)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 84;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 84;
			end
			default: begin
				idle_pct  = 33;
				stall_pct = 33;
			end
		endcase
	endtask

	// Offer one request after a random gap and hold it until accepted
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
	endtask

	// Drain, let the block settle, then write the capacity register
	task automatic write_capacity(input logic [CDQ_CAP_W-1:0] cap);
		req_valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		int                    seg;
		int                    n;
		logic [CDQ_DATA_W-1:0] fill_value;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(0);

		// refused operations on an empty deque and the unused modes
		send_request(make_req(MODE_POP_FRONT, 32'h0000_0000));
		send_request(make_req(MODE_POP_REAR, 32'hFFFF_FFFF));
		send_request(make_req(MODE_PEEK_FRONT, 32'h0000_0000));
		send_request(make_req(MODE_UNUSED_HI, 32'hFFFF_FFFF));
		send_request(make_req(MODE_UNUSED_LO, 32'h0000_0000));

		// fill every slot so later reads never meet an unwritten entry
		for (n = 0; n < CDQ_DEPTH; n++) begin
			fill_value = (n == 0) ? 32'h0000_0000 : (n == 1) ? 32'hFFFF_FFFF : $urandom;
			send_request(make_req(MODE_PUSH_REAR, fill_value));
		end

		// refused pushes when full, then each operation once more
		send_request(make_req(MODE_PUSH_REAR, 32'hFFFF_FFFF));
		send_request(make_req(MODE_PUSH_FRONT, 32'hFFFF_FFFF));
		send_request(make_req(MODE_PEEK_FRONT, 32'h0000_0000));
		send_request(make_req(MODE_POP_FRONT, 32'h0000_0000));
		send_request(make_req(MODE_POP_REAR, 32'h0000_0000));
		send_request(make_req(MODE_PUSH_FRONT, 32'hFFFF_FFFF));
		send_request(make_req(MODE_CLEAR, 32'hFFFF_FFFF));

		// random segments, each with its own capacity and idling; no clear before
		// a capacity change, so the deque often shrinks while holding data
		for (seg = 0; seg < SEGMENTS; seg++) begin
			write_capacity(capacity_for(seg));
			set_idling(seg % 4);
			segment = seg;
			for (n = 0; n < SEGMENT_ITEMS; n++) begin
				send_request(random_request(((n / CHUNK_ITEMS) % 2) == 0));
			end
		end

		// wait for the last results, then give the verdict
		req_valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
design/cdq_pkg.sv
design/cdq_cell.sv
design/cdq_ctrl.sv
design/circular_deque.sv
test/deque_checker.sv
test/testbench.sv
